// File: rtl/core/stl_pkg.sv
`default_nettype none

package stl_pkg;

  localparam int MAX_LISTENERS_DEF = 8;
  localparam int ENTITY_W          = 64;
  localparam int UID_W             = 16;
  localparam int CONN_W            = 4;
  localparam int OP_W              = 2;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic [ENTITY_W-1:0] entity;
    logic [UID_W-1:0]    uid;
  } entry_t;

  typedef struct packed {
    logic              valid;
    logic              ok;
    logic [CONN_W-1:0] count;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_MOVE,
    ST_DONE
  } st_t;

endpackage

`default_nettype wire

// File: rtl/core/stl_store.sv
`default_nettype none

module stl_store #(
  parameter int DEPTH = 8,
  parameter int IDX_W = 3
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [IDX_W-1:0]     waddr,
  input  wire stl_pkg::entry_t      wdata,
  input  wire logic [IDX_W-1:0]     raddr,
  output stl_pkg::entry_t           rdata
);
  import stl_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/core/stl_ctrl.sv
`default_nettype none

module stl_ctrl #(
  parameter int MAX_LISTENERS = 8,
  parameter int IDX_W         = 3,
  parameter int CNT_W         = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [stl_pkg::OP_W-1:0]      in_opcode,
  input  wire logic [stl_pkg::ENTITY_W-1:0]  in_entity_id,
  input  wire logic [stl_pkg::UID_W-1:0]     in_unique_id,
  output stl_pkg::res_t                      res,
  input  wire logic                          res_ready,
  output logic                               mem_we,
  output logic [IDX_W-1:0]                   mem_waddr,
  output stl_pkg::entry_t                    mem_wdata,
  output logic [IDX_W-1:0]                   mem_raddr,
  input  wire stl_pkg::entry_t               mem_rdata
);
  import stl_pkg::*;

  st_t              state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  entry_t           key_r, key_nxt;
  logic             ok_r, ok_nxt;

  logic [CNT_W-1:0] last_w;
  logic [IDX_W-1:0] last_idx;
  logic             hit;
  logic             at_last;
  logic             full;

  assign last_w   = cnt_r - 1'b1;
  assign last_idx = last_w[IDX_W-1:0];
  // One shared compare: the entry read last cycle against the search key.
  assign hit      = (mem_rdata == key_r);
  assign at_last  = (CNT_W'(idx_r) == last_w);
  assign full     = (cnt_r == CNT_W'(MAX_LISTENERS));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_opcode == OP_REMOVE && cnt_r != '0) begin
            state_nxt = ST_CMP;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_CMP: begin
        if (hit && !at_last) begin
          state_nxt = ST_MOVE;
        end else if (hit || at_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_MOVE: state_nxt = ST_DONE;
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    key_nxt   = key_r;
    ok_nxt    = ok_r;
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cnt_r[IDX_W-1:0];
    mem_wdata = '{entity: in_entity_id, uid: in_unique_id};
    mem_raddr = '0;
    res.valid = 1'b0;
    res.ok    = ok_r;
    res.count = CONN_W'(cnt_r);
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        // Entry zero is read every idle cycle so a remove can compare at once.
        if (in_valid) begin
          key_nxt = '{entity: in_entity_id, uid: in_unique_id};
          idx_nxt = '0;
          ok_nxt  = 1'b0;
          case (in_opcode)
            OP_ADD: begin
              if (!full) begin
                mem_we  = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
                ok_nxt  = 1'b1;
              end
            end
            OP_REMOVE: ok_nxt = 1'b0;
            OP_CLEAR: begin
              cnt_nxt = '0;
              ok_nxt  = 1'b1;
            end
            default: ok_nxt = 1'b0;
          endcase
        end
      end
      ST_CMP: begin
        if (hit) begin
          ok_nxt = 1'b1;
          if (at_last) begin
            cnt_nxt = last_w;
          end else begin
            mem_raddr = last_idx;
          end
        end else if (!at_last) begin
          idx_nxt   = idx_r + 1'b1;
          mem_raddr = idx_r + 1'b1;
        end
      end
      ST_MOVE: begin
        // The last entry fills the hole left by the match.
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = mem_rdata;
        cnt_nxt   = last_w;
      end
      ST_DONE: res.valid = 1'b1;
      default: res.valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    key_r <= key_nxt;
    ok_r  <= ok_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/core/stream_listener_table.sv
`default_nettype none
// Add, clear and unused opcodes, and a remove on an empty table: the control goes
// from idle straight to done, and the result is then registered in the output stage.
// Remove: the compare state scans the entries in turn; a match before the last entry
// goes on to the move state, which puts the last entry into the hole. One item is
// worked at a time: the next input beat is taken once the result is registered.
// Synchronous active-low reset empties the table; stored entries are not cleared.

module stream_listener_table #(
  parameter int MAX_LISTENERS = stl_pkg::MAX_LISTENERS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [stl_pkg::OP_W-1:0]      in_opcode,
  input  wire logic [stl_pkg::ENTITY_W-1:0]  in_entity_id,
  input  wire logic [stl_pkg::UID_W-1:0]     in_unique_id,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_ok,
  output logic [stl_pkg::CONN_W-1:0]         out_connections
);
  import stl_pkg::*;

  localparam int IDX_W = (MAX_LISTENERS > 1) ? $clog2(MAX_LISTENERS) : 1;
  localparam int CNT_W = $clog2(MAX_LISTENERS + 1);

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  entry_t            mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;
  entry_t            mem_rdata;
  res_t              res;
  logic              res_ready;

  logic              out_valid_r, out_valid_nxt;
  logic              out_ok_r;
  logic [CONN_W-1:0] out_conn_r;

  stl_store #(
    .DEPTH (MAX_LISTENERS),
    .IDX_W (IDX_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  stl_ctrl #(
    .MAX_LISTENERS (MAX_LISTENERS),
    .IDX_W         (IDX_W),
    .CNT_W         (CNT_W)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_entity_id (in_entity_id),
    .in_unique_id (in_unique_id),
    .res          (res),
    .res_ready    (res_ready),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  // The output register takes a new result once the previous beat is gone.
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      out_ok_r   <= res.ok;
      out_conn_r <= res.count;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_connections = out_conn_r;

endmodule

`default_nettype wire
